/* rtl/mct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the mouse cursor tracker: register indexes,
// reset values of the configuration registers and acceleration thresholds.
// ----------------------------------------------------------------------------
package mct_pkg;

    // default coordinate width of the cursor position
    localparam int COORD_BITS_DEF = 12;

    // field widths
    localparam int DELTA_IN_W  = 16;
    localparam int DELTA_OUT_W = 12;
    localparam int BUTTON_W    = 8;
    localparam int GAIN_W      = 5;
    localparam int LIMIT_W     = 11;
    localparam int SCREEN_W    = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    // acceleration thresholds on the delta magnitude
    localparam int NEAR_MAG = 2;
    localparam int MID_MAG  = 6;

    // left button position in the button bits
    localparam int LEFT_BIT = 0;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_GAIN    = 3'd0,
        CFG_MEDIUM_GAIN   = 3'd1,
        CFG_DELTA_LIMIT   = 3'd2,
        CFG_SCREEN_WIDTH  = 3'd3,
        CFG_SCREEN_HEIGHT = 3'd4
    } cfg_idx_t;

    // configuration reset values
    localparam logic [GAIN_W-1:0]   SMALL_GAIN_RST    = 5'd3;
    localparam logic [GAIN_W-1:0]   MEDIUM_GAIN_RST   = 5'd2;
    localparam logic [LIMIT_W-1:0]  DELTA_LIMIT_RST   = 11'd64;
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

endpackage

/* rtl/mct_accel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_accel
// Acceleration of one motion delta: gain by magnitude band, then a symmetric
// saturation to the delta limit. Pure combinational logic.
// ----------------------------------------------------------------------------
module mct_accel
    import mct_pkg::*;
(
    input  logic signed [DELTA_IN_W-1:0]  delta,
    input  logic        [GAIN_W-1:0]      small_gain,
    input  logic        [GAIN_W-1:0]      medium_gain,
    input  logic        [LIMIT_W-1:0]     delta_limit,
    output logic signed [DELTA_OUT_W-1:0] scaled
);

    localparam int EXT_W  = DELTA_IN_W + 1;
    localparam int PROD_W = 10;

    logic signed [EXT_W-1:0]  delta_ext;
    logic signed [EXT_W-1:0]  mag;
    logic signed [3:0]        delta_low;
    logic        [GAIN_W-1:0] gain_sel;
    logic signed [PROD_W-1:0] prod;
    logic signed [EXT_W-1:0]  gained;
    logic signed [EXT_W-1:0]  lim;
    logic signed [EXT_W-1:0]  lim_neg;
    logic signed [EXT_W-1:0]  clamped;

    // magnitude band and gain selection
    always_comb begin
        delta_ext = EXT_W'(delta);
        mag       = delta[DELTA_IN_W-1] ? -delta_ext : delta_ext;
        delta_low = delta[3:0];
        gain_sel  = (mag <= EXT_W'(NEAR_MAG)) ? small_gain : medium_gain;
        prod      = PROD_W'(delta_low) * $signed({{(PROD_W-GAIN_W){1'b0}}, gain_sel});
        if (mag == '0) begin
            gained = '0;
        end else if (mag <= EXT_W'(MID_MAG)) begin
            gained = EXT_W'(prod);
        end else begin
            gained = delta_ext;
        end
    end

    // symmetric saturation
    always_comb begin
        lim     = $signed({{(EXT_W-LIMIT_W){1'b0}}, delta_limit});
        lim_neg = -lim;
        if (gained > lim) begin
            clamped = lim;
        end else if (gained < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = gained;
        end
        scaled = clamped[DELTA_OUT_W-1:0];
    end

endmodule

/* rtl/mouse_cursor_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_cursor_tracker_top
// Cursor tracker for relative mouse reports with two-band acceleration,
// screen clamping and left button edge detection.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one mouse report per transaction (delta_x, delta_y,
//   button_bits). m_ channel: one result per report (pos_x, pos_y, moved,
//   left_press, left_release, drag_motion), in report order.
//   cfg channel: register writes, always ready; index 0 small_gain,
//   1 medium_gain, 2 delta_limit, 3 screen_width, 4 screen_height; other
//   indexes are dropped. Write only while no report is in flight.
//   Path: an accepted report waits in the input register, then moves to the
//   result register that drives m_. Throughput: one report per cycle while
//   m_ready stays high; the cursor update between the two is combinational.
//   Stall: when m_ready is low the result holds; one more report waits in
//   the input register, then s_ready drops until the result is taken.
//   Reset: configuration registers return to their defaults, the cursor goes
//   to (0,0); the first report after reset sets the button baseline, no edges.
// ----------------------------------------------------------------------------
module mouse_cursor_tracker_top
    import mct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // report input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DELTA_IN_W-1:0] s_delta_x,
    input  logic signed [DELTA_IN_W-1:0] s_delta_y,
    input  logic        [BUTTON_W-1:0]   s_button_bits,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [COORD_BITS-1:0] m_pos_x,
    output logic        [COORD_BITS-1:0] m_pos_y,
    output logic                         m_moved,
    output logic                         m_left_press,
    output logic                         m_left_release,
    output logic                         m_drag_motion,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam int AX_W  = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;
    localparam int SUM_W = AX_W + 2;
    localparam logic [SUM_W-1:0] COORD_TOP =
        {{(SUM_W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    // configuration registers
    logic [GAIN_W-1:0]   small_gain_reg;
    logic [GAIN_W-1:0]   medium_gain_reg;
    logic [LIMIT_W-1:0]  delta_limit_reg;
    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;

    // input stage
    logic                         in_valid_reg;
    logic signed [DELTA_IN_W-1:0] in_dx_reg;
    logic signed [DELTA_IN_W-1:0] in_dy_reg;
    logic        [BUTTON_W-1:0]   in_btn_reg;

    // tracker state
    logic [COORD_BITS-1:0] cursor_col_reg;
    logic [COORD_BITS-1:0] cursor_row_reg;
    logic [BUTTON_W-1:0]   last_btn_reg;
    logic                  baseline_reg;

    // result stage
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_moved_reg;
    logic                  out_press_reg;
    logic                  out_release_reg;
    logic                  out_drag_reg;

    // datapath
    logic                          out_free;
    logic                          advance;
    logic                          s_take;
    logic signed [DELTA_OUT_W-1:0] sdx;
    logic signed [DELTA_OUT_W-1:0] sdy;
    logic signed [SUM_W-1:0]       sum_x;
    logic signed [SUM_W-1:0]       sum_y;
    logic        [SUM_W-1:0]       max_x;
    logic        [SUM_W-1:0]       max_y;
    logic        [SUM_W-1:0]       size_w_m1;
    logic        [SUM_W-1:0]       size_h_m1;
    logic        [COORD_BITS-1:0]  col_next;
    logic        [COORD_BITS-1:0]  row_next;
    logic                          moved_next;
    logic                          left_now;
    logic                          left_before;
    logic                          press_next;
    logic                          release_next;

    // handshake
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_gain_reg    <= SMALL_GAIN_RST;
            medium_gain_reg   <= MEDIUM_GAIN_RST;
            delta_limit_reg   <= DELTA_LIMIT_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SMALL_GAIN:    small_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_MEDIUM_GAIN:   medium_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_DELTA_LIMIT:   delta_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_dx_reg  <= s_delta_x;
            in_dy_reg  <= s_delta_y;
            in_btn_reg <= s_button_bits;
        end
    end

    // delta acceleration per axis
    mct_accel u_accel_x (
        .delta       (in_dx_reg),
        .small_gain  (small_gain_reg),
        .medium_gain (medium_gain_reg),
        .delta_limit (delta_limit_reg),
        .scaled      (sdx)
    );

    mct_accel u_accel_y (
        .delta       (in_dy_reg),
        .small_gain  (small_gain_reg),
        .medium_gain (medium_gain_reg),
        .delta_limit (delta_limit_reg),
        .scaled      (sdy)
    );

    // screen limits: size minus one, zero size gives zero, capped at coord range
    always_comb begin
        size_w_m1 = (screen_width_reg == '0) ? '0
                  : SUM_W'(screen_width_reg) - SUM_W'(1);
        size_h_m1 = (screen_height_reg == '0) ? '0
                  : SUM_W'(screen_height_reg) - SUM_W'(1);
        max_x = (size_w_m1 > COORD_TOP) ? COORD_TOP : size_w_m1;
        max_y = (size_h_m1 > COORD_TOP) ? COORD_TOP : size_h_m1;
    end

    // cursor update with y inverted, then clamp to the screen
    always_comb begin
        sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, cursor_col_reg}) + SUM_W'(sdx);
        sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, cursor_row_reg}) - SUM_W'(sdy);
        if (sum_x < 0) begin
            col_next = '0;
        end else if (sum_x > $signed(max_x)) begin
            col_next = max_x[COORD_BITS-1:0];
        end else begin
            col_next = sum_x[COORD_BITS-1:0];
        end
        if (sum_y < 0) begin
            row_next = '0;
        end else if (sum_y > $signed(max_y)) begin
            row_next = max_y[COORD_BITS-1:0];
        end else begin
            row_next = sum_y[COORD_BITS-1:0];
        end
    end

    // motion and left button edges; the edges are suppressed until the baseline exists
    always_comb begin
        moved_next   = (col_next != cursor_col_reg) || (row_next != cursor_row_reg);
        left_now     = in_btn_reg[LEFT_BIT];
        left_before  = last_btn_reg[LEFT_BIT];
        press_next   = baseline_reg && left_now && !left_before;
        release_next = baseline_reg && !left_now && left_before;
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            last_btn_reg   <= '0;
            baseline_reg   <= 1'b0;
        end else if (advance) begin
            cursor_col_reg <= col_next;
            cursor_row_reg <= row_next;
            last_btn_reg   <= in_btn_reg;
            baseline_reg   <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_x_reg       <= col_next;
            out_y_reg       <= row_next;
            out_moved_reg   <= moved_next;
            out_press_reg   <= press_next;
            out_release_reg <= release_next;
            out_drag_reg    <= moved_next && left_now;
        end
    end

    // result ports
    assign m_valid        = out_valid_reg;
    assign m_pos_x        = out_x_reg;
    assign m_pos_y        = out_y_reg;
    assign m_moved        = out_moved_reg;
    assign m_left_press   = out_press_reg;
    assign m_left_release = out_release_reg;
    assign m_drag_motion  = out_drag_reg;

endmodule
